// ----- rtl/mm_pkg.sv -----
// ----------------------------------------------------------------------------
// mm_pkg
// Shared types, constants and helpers for the matrix multiply block.
// ----------------------------------------------------------------------------
package mm_pkg;

    localparam int MAX_DIM     = 8;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int DIM_W       = 4;                        // config register width
    localparam int IDX_W       = $clog2(MAX_DIM);          // row/col/k index
    localparam int ADDR_W      = $clog2(STORE_DEPTH);      // operand store address
    localparam int CNT_W       = ADDR_W + 1;               // load counter, holds depth
    localparam int ELEM_W      = 16;                       // Q8.8 element
    localparam int PROD_W      = 2 * ELEM_W;               // Q16.16 product
    localparam int ACC_W       = 35;                       // Q19.16 dot product
    localparam int ACTION_W    = 2;
    localparam int REG_IDX_W   = 2;

    // input transaction action codes
    localparam logic [ACTION_W-1:0] ACT_LOAD_A  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LOAD_B  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_COMPUTE = 2'd2;

    // config register indexes
    localparam logic [REG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_COLS_B    = 2'd2;

    // result status codes
    localparam logic STATUS_OK         = 1'b0;
    localparam logic STATUS_INCOMPLETE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_ACC,
        S_OUT,
        S_ERR
    } mm_state_t;

    // zero acts as one, anything above MAX_DIM acts as MAX_DIM
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r);
        logic [DIM_W-1:0] d;
        if (r == '0) begin
            d = DIM_W'(1);
        end else if (r > DIM_W'(MAX_DIM)) begin
            d = DIM_W'(MAX_DIM);
        end else begin
            d = r;
        end
        return d;
    endfunction

endpackage

// ----- rtl/matrix_multiply.sv -----
// ----------------------------------------------------------------------------
// matrix_multiply
// Dense C = A x B on signed Q8.8 operands, exact Q19.16 results.
// ----------------------------------------------------------------------------
// Usage:
//   Set rows_a, inner_dim and cols_b through the cfg port (cfg_we, cfg_index,
//   cfg_wdata) while the block is idle. Then stream A and B elements in
//   row-major order on the s_ channel (action LOAD_A / LOAD_B); each matrix
//   has its own write counter, and elements past the configured count are
//   dropped. A COMPUTE transaction emits all rows_a*cols_b elements of C on
//   the m_ channel in row-major order, last set on the final one, or a single
//   result with status=1 if either matrix is incomplete. Compute clears both
//   load counters.
// Timing:
//   Loads are accepted back to back. Compute runs on one shared
//   16x16 multiplier and one 35-bit accumulator: every k step runs a store
//   read, a multiply and an accumulate in turn, and each C element ends in
//   an output step. s_ready is low for the whole run, and also while an
//   error result is sent.
// Reset / stall:
//   aresetn (sync, active low) restores dims to 1 and clears the counters;
//   operand stores are not cleared. A stalled m_ready holds the current
//   result in the output register and the sequencer waits for it.
// ----------------------------------------------------------------------------
module matrix_multiply
    import mm_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,

    // config write port
    input  logic                     cfg_we,
    input  logic [REG_IDX_W-1:0]     cfg_index,
    input  logic [DIM_W-1:0]         cfg_wdata,

    // input transactions
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [ACTION_W-1:0]      s_action,
    input  logic signed [ELEM_W-1:0] s_value,

    // result transactions
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [ACC_W-1:0]  m_product_value,
    output logic [IDX_W-1:0]         m_row_index,
    output logic [IDX_W-1:0]         m_col_index,
    output logic                     m_status,
    output logic                     m_last
);

    // ------------------------------------------------------------------
    // Config registers (raw 4-bit values; clamped where used)
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] rows_a_reg, inner_dim_reg, cols_b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_a_reg    <= DIM_W'(1);
            inner_dim_reg <= DIM_W'(1);
            cols_b_reg    <= DIM_W'(1);
        end else if (cfg_we) begin
            case (cfg_index)
                REG_ROWS_A:    rows_a_reg    <= cfg_wdata;
                REG_INNER_DIM: inner_dim_reg <= cfg_wdata;
                REG_COLS_B:    cols_b_reg    <= cfg_wdata;
                default:       ;
            endcase
        end
    end

    logic [DIM_W-1:0] dim_m, dim_n, dim_p;
    logic [CNT_W-1:0] need_a, need_b;

    assign dim_m  = eff_dim(rows_a_reg);
    assign dim_n  = eff_dim(inner_dim_reg);
    assign dim_p  = eff_dim(cols_b_reg);
    assign need_a = CNT_W'(dim_m) * CNT_W'(dim_n);
    assign need_b = CNT_W'(dim_n) * CNT_W'(dim_p);

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    mm_state_t state_reg, state_next;

    logic [CNT_W-1:0] loaded_a_reg, loaded_a_next;
    logic [CNT_W-1:0] loaded_b_reg, loaded_b_next;
    logic [IDX_W-1:0] i_reg, i_next;       // row of C
    logic [IDX_W-1:0] j_reg, j_next;       // column of C
    logic [IDX_W-1:0] k_reg, k_next;       // dot product step

    logic signed [ELEM_W-1:0] a_rd_reg, b_rd_reg;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;

    logic                     m_valid_reg, m_valid_next;
    logic signed [ACC_W-1:0]  m_product_value_reg, m_product_value_next;
    logic [IDX_W-1:0]         m_row_index_reg, m_row_index_next;
    logic [IDX_W-1:0]         m_col_index_reg, m_col_index_next;
    logic                     m_status_reg, m_status_next;
    logic                     m_last_reg, m_last_next;

    logic in_acc, out_free, out_load;
    logic wr_a_en, wr_b_en;
    logic i_last, j_last, k_last;

    assign in_acc   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign i_last = ({1'b0, i_reg} == DIM_W'(dim_m - DIM_W'(1)));
    assign j_last = ({1'b0, j_reg} == DIM_W'(dim_p - DIM_W'(1)));
    assign k_last = ({1'b0, k_reg} == DIM_W'(dim_n - DIM_W'(1)));

    assign wr_a_en = in_acc && (s_action == ACT_LOAD_A) && (loaded_a_reg < need_a);
    assign wr_b_en = in_acc && (s_action == ACT_LOAD_B) && (loaded_b_reg < need_b);

    // operand addresses: A[i][k] and B[k][j], row-major
    logic [CNT_W-1:0]  addr_a_full, addr_b_full;
    logic [ADDR_W-1:0] addr_a, addr_b;

    assign addr_a_full = CNT_W'(i_reg) * CNT_W'(dim_n) + CNT_W'(k_reg);
    assign addr_b_full = CNT_W'(k_reg) * CNT_W'(dim_p) + CNT_W'(j_reg);
    assign addr_a      = addr_a_full[ADDR_W-1:0];
    assign addr_b      = addr_b_full[ADDR_W-1:0];

    // ------------------------------------------------------------------
    // Operand stores: one write port, one registered read port each
    // ------------------------------------------------------------------
    logic [ELEM_W-1:0] store_a_mem [STORE_DEPTH];
    logic [ELEM_W-1:0] store_b_mem [STORE_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_a_en) begin
            store_a_mem[loaded_a_reg[ADDR_W-1:0]] <= s_value;
        end
        a_rd_reg <= store_a_mem[addr_a];
    end

    always_ff @(posedge aclk) begin
        if (wr_b_en) begin
            store_b_mem[loaded_b_reg[ADDR_W-1:0]] <= s_value;
        end
        b_rd_reg <= store_b_mem[addr_b];
    end

    // ------------------------------------------------------------------
    // State and control registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            loaded_a_reg <= '0;
            loaded_b_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            loaded_a_reg <= loaded_a_next;
            loaded_b_reg <= loaded_b_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // datapath and payload, no reset needed
    always_ff @(posedge aclk) begin
        i_reg               <= i_next;
        j_reg               <= j_next;
        k_reg               <= k_next;
        prod_reg            <= prod_next;
        acc_reg             <= acc_next;
        m_product_value_reg <= m_product_value_next;
        m_row_index_reg     <= m_row_index_next;
        m_col_index_reg     <= m_col_index_next;
        m_status_reg        <= m_status_next;
        m_last_reg          <= m_last_next;
    end

    // ------------------------------------------------------------------
    // Next state and outputs
    // ------------------------------------------------------------------
    always_comb begin
        state_next           = state_reg;
        loaded_a_next        = loaded_a_reg;
        loaded_b_next        = loaded_b_reg;
        i_next               = i_reg;
        j_next               = j_reg;
        k_next               = k_reg;
        prod_next            = prod_reg;
        acc_next             = acc_reg;
        out_load             = 1'b0;
        m_product_value_next = m_product_value_reg;
        m_row_index_next     = m_row_index_reg;
        m_col_index_next     = m_col_index_reg;
        m_status_next        = m_status_reg;
        m_last_next          = m_last_reg;
        s_ready              = 1'b0;

        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (in_acc) begin
                    case (s_action)
                        ACT_LOAD_A: begin
                            if (wr_a_en) begin
                                loaded_a_next = loaded_a_reg + CNT_W'(1);
                            end
                        end
                        ACT_LOAD_B: begin
                            if (wr_b_en) begin
                                loaded_b_next = loaded_b_reg + CNT_W'(1);
                            end
                        end
                        ACT_COMPUTE: begin
                            loaded_a_next = '0;
                            loaded_b_next = '0;
                            i_next        = '0;
                            j_next        = '0;
                            k_next        = '0;
                            acc_next      = '0;
                            if (loaded_a_reg < need_a || loaded_b_reg < need_b) begin
                                state_next = S_ERR;
                            end else begin
                                state_next = S_READ;
                            end
                        end
                        default: ;   // unused code: dropped
                    endcase
                end
            end

            // store read data lands in a_rd_reg / b_rd_reg
            S_READ: begin
                state_next = S_MUL;
            end

            S_MUL: begin
                prod_next  = a_rd_reg * b_rd_reg;
                state_next = S_ACC;
            end

            S_ACC: begin
                acc_next = acc_reg + ACC_W'(prod_reg);
                if (k_last) begin
                    state_next = S_OUT;
                end else begin
                    k_next     = k_reg + IDX_W'(1);
                    state_next = S_READ;
                end
            end

            S_OUT: begin
                if (out_free) begin
                    out_load             = 1'b1;
                    m_product_value_next = acc_reg;
                    m_row_index_next     = i_reg;
                    m_col_index_next     = j_reg;
                    m_status_next        = STATUS_OK;
                    m_last_next          = i_last && j_last;
                    acc_next             = '0;
                    k_next               = '0;
                    state_next           = S_READ;
                    if (j_last) begin
                        j_next = '0;
                        if (i_last) begin
                            state_next = S_IDLE;
                        end else begin
                            i_next = i_reg + IDX_W'(1);
                        end
                    end else begin
                        j_next = j_reg + IDX_W'(1);
                    end
                end
            end

            S_ERR: begin
                if (out_free) begin
                    out_load             = 1'b1;
                    m_product_value_next = '0;
                    m_row_index_next     = '0;
                    m_col_index_next     = '0;
                    m_status_next        = STATUS_INCOMPLETE;
                    m_last_next          = 1'b1;
                    state_next           = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_product_value = m_product_value_reg;
    assign m_row_index     = m_row_index_reg;
    assign m_col_index     = m_col_index_reg;
    assign m_status        = m_status_reg;
    assign m_last          = m_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // load counters never run past the store depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        (loaded_a_reg <= CNT_W'(STORE_DEPTH)) && (loaded_b_reg <= CNT_W'(STORE_DEPTH)))
        else $error("load counter beyond store depth");

    // every compute leaves both counters cleared
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && s_action == ACT_COMPUTE) |=> (loaded_a_reg == '0 && loaded_b_reg == '0))
        else $error("compute did not clear load counters");

    // an error result is a lone, zeroed, final transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg == STATUS_INCOMPLETE) |->
            (m_last_reg && m_product_value_reg == '0 && m_row_index_reg == '0
             && m_col_index_reg == '0))
        else $error("malformed error result");

    // the output register is only reloaded when it is free
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free)
        else $error("result overwritten before taken");

endmodule

// ----- tb/sv/tb_matrix_multiply.sv -----
// ----------------------------------------------------------------------------
// tb_matrix_multiply
// Self-checking bench for the matrix multiply block. A short directed table
// covers the operand extremes, the ignored load and action cases and the
// incomplete-matrix error. Random load/compute jobs follow, on shapes that
// change between jobs. Every result transaction is checked against an
// in-bench model of C = A x B or against a hand-typed result.
// ----------------------------------------------------------------------------
module tb_matrix_multiply;
    import mm_pkg::*;

    // action code the block must ignore
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    // random job flavors
    localparam int JOB_CLEAN   = 0;   // exact operand counts, then compute
    localparam int JOB_EXTRA   = 1;   // loads past the configured count
    localparam int JOB_SHORT   = 2;   // one or both matrices incomplete
    localparam int JOB_RESHAPE = 3;   // load, change dims, then compute

    localparam int RANDOM_ITEMS   = 270;
    localparam int SETTLE_CYCLES  = 8;     // idle cycles before a config write
    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transaction at all
    localparam int MAX_REPORTS    = 10;
    localparam int DIR_ROWS       = 35;

    // ------------------------------------------------------------------------
    // DUT signals, all inputs known from time zero
    // ------------------------------------------------------------------------
    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     cfg_we    = 1'b0;
    logic [REG_IDX_W-1:0]     cfg_index = '0;
    logic [DIM_W-1:0]         cfg_wdata = '0;
    logic                     s_valid   = 1'b0;
    logic                     s_ready;
    logic [ACTION_W-1:0]      s_action  = '0;
    logic [ELEM_W-1:0]        s_value   = '0;
    logic                     m_valid;
    logic                     m_ready   = 1'b0;
    logic signed [ACC_W-1:0]  m_product_value;
    logic [IDX_W-1:0]         m_row_index;
    logic [IDX_W-1:0]         m_col_index;
    logic                     m_status;
    logic                     m_last;

    matrix_multiply uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_value         (s_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_product_value (m_product_value),
        .m_row_index     (m_row_index),
        .m_col_index     (m_col_index),
        .m_status        (m_status),
        .m_last          (m_last)
    );

    always #2 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    typedef struct {
        logic signed [ACC_W-1:0] product;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic                    status;
        logic                    last;
    } c_elem_t;

    // One directed row: either a config write (code = register index,
    // data[3:0] = value) or an input transaction (code = action). Rows with
    // typed set carry a single hand-computed 1x1 result or an error.
    typedef struct packed {
        logic                    is_cfg;
        logic [1:0]              code;
        logic [ELEM_W-1:0]       data;
        logic                    typed;
        logic signed [ACC_W-1:0] t_product;
        logic                    t_status;
    } dir_row_t;

    c_elem_t expected_c[$];       // C elements still owed by the DUT
    int      mismatches      = 0;
    int      effective_items = 0; // transactions that changed state or emitted
    int      idle_cycles     = 0;
    int      send_idle       = 0; // percent of cycles the sender holds off
    int      recv_idle       = 0; // percent of cycles m_ready is low

    // sideband travelling with each input transaction: hand-typed result
    logic                    typed_flag    = 1'b0;
    logic signed [ACC_W-1:0] typed_product = '0;
    logic                    typed_status  = STATUS_OK;

    // model copy of the block: dims, operand stores, load counters
    logic [DIM_W-1:0]  rows_cfg  = DIM_W'(1);
    logic [DIM_W-1:0]  inner_cfg = DIM_W'(1);
    logic [DIM_W-1:0]  cols_cfg  = DIM_W'(1);
    logic [ELEM_W-1:0] a_store [STORE_DEPTH];
    logic [ELEM_W-1:0] b_store [STORE_DEPTH];
    int unsigned       a_count   = 0;
    int unsigned       b_count   = 0;

    dir_row_t dir_rows [DIR_ROWS] = '{
        // compute straight after reset: nothing loaded
        '{1'b0, ACT_COMPUTE, 16'h0000, 1'b1, 35'sd0, STATUS_INCOMPLETE},
        // largest positive squared
        '{1'b0, ACT_LOAD_A,  16'h7FFF, 1'b0, 35'sd0, STATUS_OK},
        '{1'b0, ACT_LOAD_B,  16'h7FFF, 1'b0, 35'sd0, STATUS_OK},
        '{1'b0, ACT_COMPUTE, 16'h0000, 1'b1, 35'sd1073676289, STATUS_OK},
        // most negative squared
        '{1'b0, ACT_LOAD_A,  16'h8000, 1'b0, 35'sd0, STATUS_OK},
        '{1'b0, ACT_LOAD_B,  16'h8000, 1'b0, 35'sd0, STATUS_OK},
        '{1'b0, ACT_COMPUTE, 16'hFFFF, 1'b1, 35'sd1073741824, STATUS_OK},
        // mixed extremes, B loaded first
        '{1'b0, ACT_LOAD_B,  16'h7FFF, 1'b0, 35'sd0, STATUS_OK},
        '{1'b0, ACT_LOAD_A,  16'h8000, 1'b0, 35'sd0, STATUS_OK},
        '{1'b0, ACT_COMPUTE, 16'h0000, 1'b1, -35'sd1073709056, STATUS_OK},
        // second load of each matrix is past the count and dropped
        '{1'b0, ACT_LOAD_A,  16'h0001, 1'b0, 35'sd0, STATUS_OK},
        '{1'b0, ACT_LOAD_A,  16'h0002, 1'b0, 35'sd0, STATUS_OK},
        '{1'b0, ACT_LOAD_B,  16'h0003, 1'b0, 35'sd0, STATUS_OK},
        '{1'b0, ACT_LOAD_B,  16'h0004, 1'b0, 35'sd0, STATUS_OK},
        '{1'b0, ACT_COMPUTE, 16'h0000, 1'b1, 35'sd3, STATUS_OK},
        // unused action code in the middle of a load sequence
        '{1'b0, ACT_LOAD_A,  16'h0005, 1'b0, 35'sd0, STATUS_OK},
        '{1'b0, ACT_UNUSED,  16'hFFFF, 1'b0, 35'sd0, STATUS_OK},
        '{1'b0, ACT_LOAD_B,  16'h0006, 1'b0, 35'sd0, STATUS_OK},
        '{1'b0, ACT_COMPUTE, 16'h0000, 1'b1, 35'sd30, STATUS_OK},
        // B missing
        '{1'b0, ACT_LOAD_A,  16'h0007, 1'b0, 35'sd0, STATUS_OK},
        '{1'b0, ACT_COMPUTE, 16'h0000, 1'b1, 35'sd0, STATUS_INCOMPLETE},
        // zero dims act as one
        '{1'b1, REG_ROWS_A,    16'h0000, 1'b0, 35'sd0, STATUS_OK},
        '{1'b1, REG_INNER_DIM, 16'h0000, 1'b0, 35'sd0, STATUS_OK},
        '{1'b1, REG_COLS_B,    16'h0000, 1'b0, 35'sd0, STATUS_OK},
        '{1'b0, ACT_LOAD_A,  16'hFFFF, 1'b0, 35'sd0, STATUS_OK},
        '{1'b0, ACT_LOAD_B,  16'hFFFF, 1'b0, 35'sd0, STATUS_OK},
        '{1'b0, ACT_COMPUTE, 16'h0000, 1'b1, 35'sd1, STATUS_OK},
        // 2x1 times 1x2 outer product, checked by the model
        '{1'b1, REG_ROWS_A,    16'h0002, 1'b0, 35'sd0, STATUS_OK},
        '{1'b1, REG_INNER_DIM, 16'h0001, 1'b0, 35'sd0, STATUS_OK},
        '{1'b1, REG_COLS_B,    16'h0002, 1'b0, 35'sd0, STATUS_OK},
        '{1'b0, ACT_LOAD_A,  16'h0100, 1'b0, 35'sd0, STATUS_OK},
        '{1'b0, ACT_LOAD_A,  16'h8000, 1'b0, 35'sd0, STATUS_OK},
        '{1'b0, ACT_LOAD_B,  16'h7FFF, 1'b0, 35'sd0, STATUS_OK},
        '{1'b0, ACT_LOAD_B,  16'hFFFF, 1'b0, 35'sd0, STATUS_OK},
        '{1'b0, ACT_COMPUTE, 16'h0000, 1'b0, 35'sd0, STATUS_OK}
    };

    // ------------------------------------------------------------------------
    // Model of the block
    // ------------------------------------------------------------------------

    // register value to dimension actually used
    function automatic int unsigned dim_used(input logic [DIM_W-1:0] r);
        if (r == '0) return 1;
        if (r > MAX_DIM) return MAX_DIM;
        return int'(r);
    endfunction

    // Apply one accepted input transaction; queue the C elements it causes.
    // took is set when the transaction changed state or produced output.
    task automatic predict_matrix_product(input logic [ACTION_W-1:0] act,
                                          input logic [ELEM_W-1:0] val,
                                          output bit took);
        int unsigned             m, n, p, i, j, k;
        logic signed [ACC_W-1:0] acc, ea, eb;
        c_elem_t                 e;
        m = dim_used(rows_cfg);
        n = dim_used(inner_cfg);
        p = dim_used(cols_cfg);
        took = 1'b0;
        case (act)
            ACT_LOAD_A: begin
                if (a_count < m * n) begin
                    a_store[a_count] = val;
                    a_count++;
                    took = 1'b1;
                end
            end
            ACT_LOAD_B: begin
                if (b_count < n * p) begin
                    b_store[b_count] = val;
                    b_count++;
                    took = 1'b1;
                end
            end
            ACT_COMPUTE: begin
                took = 1'b1;
                if (a_count < m * n || b_count < n * p) begin
                    // counts are checked against the dims in force right now
                    e = '{product: '0, row: '0, col: '0,
                          status: STATUS_INCOMPLETE, last: 1'b1};
                    expected_c.push_back(e);
                end else begin
                    for (i = 0; i < m; i++) begin
                        for (j = 0; j < p; j++) begin
                            acc = '0;
                            for (k = 0; k < n; k++) begin
                                ea  = $signed(a_store[i * n + k]);
                                eb  = $signed(b_store[k * p + j]);
                                acc = acc + ea * eb;
                            end
                            e = '{product: acc, row: IDX_W'(i), col: IDX_W'(j),
                                  status: STATUS_OK,
                                  last: (i == m - 1 && j == p - 1)};
                            expected_c.push_back(e);
                        end
                    end
                end
                a_count = 0;
                b_count = 0;
            end
            default: ;  // unused code: no effect
        endcase
    endtask

    // Track every accepted input and config transaction. Sampling at the
    // edge sees the pre-edge values driven by the bench and the DUT.
    always @(posedge aclk) begin : track_inputs
        bit took;
        int depth;
        if (aresetn) begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_ROWS_A:    rows_cfg  = cfg_wdata;
                    REG_INNER_DIM: inner_cfg = cfg_wdata;
                    REG_COLS_B:    cols_cfg  = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                depth = expected_c.size();
                predict_matrix_product(s_action, s_value, took);
                if (took) effective_items++;
                // hand-typed rows replace the model output with their own
                if (typed_flag) begin
                    while (expected_c.size() > depth) void'(expected_c.pop_back());
                    expected_c.push_back('{product: typed_product, row: '0, col: '0,
                                           status: typed_status, last: 1'b1});
                end
            end
        end
    end

    // Compare each accepted result transaction with the oldest expectation.
    always @(posedge aclk) begin : check_results
        c_elem_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_c.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("unexpected result: value=%0d row=%0d col=%0d status=%0b last=%0b",
                             m_product_value, m_row_index, m_col_index, m_status, m_last);
                mismatches++;
            end else begin
                want = expected_c.pop_front();
                if (m_product_value !== want.product || m_row_index !== want.row ||
                    m_col_index !== want.col || m_status !== want.status ||
                    m_last !== want.last) begin
                    if (mismatches < MAX_REPORTS) begin
                        $display("mismatch: expected value=%0d row=%0d col=%0d status=%0b last=%0b",
                                 want.product, want.row, want.col, want.status, want.last);
                        $display("          got      value=%0d row=%0d col=%0d status=%0b last=%0b",
                                 m_product_value, m_row_index, m_col_index, m_status, m_last);
                    end
                    mismatches++;
                end
            end
        end
    end

    // Receiver: m_ready drops at the rate of the current idle setting.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    // Watchdog: any transaction or config write restarts the count.
    always @(posedge aclk) begin
        if (!aresetn || cfg_we || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers; all run aligned to the rising edge
    // ------------------------------------------------------------------------

    // Offer one input transaction, after an optional random hold-off.
    // Valid stays high on return so back-to-back transactions never glitch.
    task automatic send_item(input logic [ACTION_W-1:0] act, input logic [ELEM_W-1:0] val,
                             input logic typed, input logic signed [ACC_W-1:0] t_prod,
                             input logic t_stat);
        if ($urandom_range(0, 99) < send_idle) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_idle);
        end
        s_valid       <= 1'b1;
        s_action      <= act;
        s_value       <= val;
        typed_flag    <= typed;
        typed_product <= t_prod;
        typed_status  <= t_stat;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_plain(input logic [ACTION_W-1:0] act, input logic [ELEM_W-1:0] val);
        send_item(act, val, 1'b0, '0, STATUS_OK);
    endtask

    // Stop sending, wait for every owed result, then let the block settle.
    // Checked on the falling edge so the queue state is final for the cycle.
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (expected_c.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One register write; cfg_we is lowered again before return, keeping it to one update per step.
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic new_shape(input logic [DIM_W-1:0] r, input logic [DIM_W-1:0] i,
                             input logic [DIM_W-1:0] c);
        wait_idle();
        write_reg(REG_ROWS_A, r);
        write_reg(REG_INNER_DIM, i);
        write_reg(REG_COLS_B, c);
    endtask

    // mostly small shapes; occasionally zero, large, or above the maximum
    function automatic logic [DIM_W-1:0] pick_dim();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return DIM_W'($urandom_range(1, 3));
        if (r < 85) return '0;
        if (r < 92) return DIM_W'($urandom_range(4, 7));
        if (r < 97) return DIM_W'(MAX_DIM);
        return DIM_W'($urandom_range(9, 15));
    endfunction

    function automatic logic [ELEM_W-1:0] rand_elem();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'hFFFF;
            3: return 16'h0000;
            default: return ELEM_W'($urandom);
        endcase
    endfunction

    function automatic int pick_job();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return JOB_CLEAN;
        if (r < 75) return JOB_EXTRA;
        if (r < 88) return JOB_SHORT;
        return JOB_RESHAPE;
    endfunction

    // One load/compute job on the current shape. A and B loads are
    // interleaved at random but each matrix stays in row-major order.
    task automatic run_job(input int kind);
        int unsigned m, n, p, na, nb, ia, ib;
        m  = dim_used(rows_cfg);
        n  = dim_used(inner_cfg);
        p  = dim_used(cols_cfg);
        na = m * n;
        nb = n * p;
        case (kind)
            JOB_EXTRA: begin
                na += $urandom_range(1, 3);
                nb += $urandom_range(0, 3);
            end
            JOB_SHORT: begin
                case ($urandom_range(0, 2))
                    0: na = $urandom_range(0, m * n - 1);
                    1: nb = $urandom_range(0, n * p - 1);
                    default: begin
                        na = $urandom_range(0, m * n - 1);
                        nb = $urandom_range(0, n * p - 1);
                    end
                endcase
            end
            default: ;
        endcase
        ia = 0;
        ib = 0;
        while (ia < na || ib < nb) begin
            if ($urandom_range(0, 19) == 0) send_plain(ACT_UNUSED, rand_elem());
            if (ib >= nb || (ia < na && $urandom_range(0, 1) == 1)) begin
                send_plain(ACT_LOAD_A, rand_elem());
                ia++;
            end else begin
                send_plain(ACT_LOAD_B, rand_elem());
                ib++;
            end
        end
        // loads done under the old dims, compute under the new ones
        if (kind == JOB_RESHAPE) new_shape(pick_dim(), pick_dim(), pick_dim());
        send_plain(ACT_COMPUTE, rand_elem());
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int base;
        int done;
        foreach (a_store[x]) a_store[x] = '0;
        foreach (b_store[x]) b_store[x] = '0;

        // phase one: sender idles a third of the time, receiver mostly stalls
        send_idle = 32;
        recv_idle = 75;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (dir_rows[r].is_cfg) begin
                wait_idle();
                write_reg(dir_rows[r].code, dir_rows[r].data[DIM_W-1:0]);
            end else begin
                send_item(dir_rows[r].code, dir_rows[r].data, dir_rows[r].typed,
                          dir_rows[r].t_product, dir_rows[r].t_status);
            end
        end

        // random jobs; start with the largest shape (rows above max clamp)
        base = effective_items;
        new_shape(DIM_W'(15), DIM_W'(MAX_DIM), DIM_W'(MAX_DIM));
        run_job(JOB_CLEAN);
        while (effective_items - base < RANDOM_ITEMS) begin
            done = effective_items - base;
            if (done >= 2 * RANDOM_ITEMS / 3) begin
                send_idle = 0;
                recv_idle = 0;
            end else if (done >= RANDOM_ITEMS / 3) begin
                send_idle = 75;
                recv_idle = 32;
            end
            if ($urandom_range(0, 99) < 30) new_shape(pick_dim(), pick_dim(), pick_dim());
            run_job(pick_job());
        end

        wait_idle();
        if (mismatches == 0 && expected_c.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
